// ----- rtl/core/fbfs_pkg.sv -----
// ----------------------------------------------------------------------------
// fbfs_pkg
// shared codes and types of the free block fit search
// ----------------------------------------------------------------------------
package fbfs_pkg;

  // command codes
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // fit policies
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FOUND = 2'd1;
  localparam logic [1:0] STAT_NOFIT = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  localparam int unsigned ID_W = 16;

  // verdict of the compare unit on one stored block
  typedef struct packed {
    logic fits;  // block is large enough
    logic take;  // block replaces the current choice
  } cmp_res_t;

endpackage

// ----- rtl/core/fbfs_mem.sv -----
// ----------------------------------------------------------------------------
// fbfs_mem
// block table storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module fbfs_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned IDX_W  = 4,
  parameter int unsigned DATA_W = 48
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/fbfs_cmp.sv -----
// ----------------------------------------------------------------------------
// fbfs_cmp
// shared compare unit: fit test, leftover and choice against the best so far
// ----------------------------------------------------------------------------
module fbfs_cmp #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic [SIZE_BITS-1:0] blk_size,
  input  logic [SIZE_BITS-1:0] req_size,
  input  logic [SIZE_BITS-1:0] best_left,
  input  logic                 have,
  input  logic [1:0]           policy,
  output logic [SIZE_BITS-1:0] left,
  output fbfs_pkg::cmp_res_t   res
);
  import fbfs_pkg::*;

  always_comb begin
    left     = blk_size - req_size;
    res.fits = (blk_size >= req_size);
    res.take = 1'b0;
    if (res.fits) begin
      case (policy)
        POL_FIRST: res.take = 1'b1;
        POL_BEST:  res.take = !have || (left < best_left);
        POL_WORST: res.take = !have || (left > best_left);
        default:   res.take = 1'b0;
      endcase
    end
  end

endmodule

// ----- rtl/core/free_block_fit_search.sv -----
// results: append, clear and unused commands give their word in the cycle after acceptance
// a query streams the stored blocks through the compare unit in S_SCAN and hands its verdict
//   to the output register from S_POST; first fit stops at its first hit, and an empty table or
//   unused policy goes straight to S_POST. flow: one item at a time, a query holds the block
//   until its verdict is handed on, the single table read port feeding one block per cycle to the compare unit
// reset: synchronous, active low, empties the table and drops any pending word
// ----------------------------------------------------------------------------
// free_block_fit_search
// ordered free block table with first, best and worst fit search
// ----------------------------------------------------------------------------
module free_block_fit_search #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned SIZE_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_entry_size,
  input  logic [15:0] in_entry_id,
  input  logic [31:0] in_request_size,
  input  logic [1:0]  in_fit_policy,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_found_id
);
  import fbfs_pkg::*;

  // table geometry
  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned EXT_W  = (SIZE_BITS > 32) ? SIZE_BITS : 32;
  localparam int unsigned DATA_W = SIZE_BITS + ID_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,  // waiting for a word
    S_SCAN = 3'b010,  // streaming the table through the compare unit
    S_POST = 3'b100   // handing the query verdict to the output register
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     rd_addr_r, rd_addr_nxt;
  logic                 pend_r, pend_nxt;      // read register holds a block
  logic                 have_r, have_nxt;      // some block chosen so far
  logic [SIZE_BITS-1:0] best_r, best_nxt;
  logic [ID_W-1:0]      pick_r, pick_nxt;
  logic [SIZE_BITS-1:0] req_r, req_nxt;
  logic [1:0]           pol_r, pol_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [ID_W-1:0]      out_found_id_r, out_found_id_nxt;

  logic                 accept;
  logic                 out_free;
  logic                 wr_en;
  logic                 rd_en;
  logic [DATA_W-1:0]    wr_data;
  logic [DATA_W-1:0]    rd_data;
  logic [SIZE_BITS-1:0] rd_size;
  logic [ID_W-1:0]      rd_id;
  logic [SIZE_BITS-1:0] left;
  cmp_res_t             cmp_res;
  logic [SIZE_BITS-1:0] in_size_m;
  logic [SIZE_BITS-1:0] in_req_m;
  logic                 full;

  // sizes are kept modulo 2^SIZE_BITS
  assign in_size_m = SIZE_BITS'(EXT_W'(in_entry_size));
  assign in_req_m  = SIZE_BITS'(EXT_W'(in_request_size));

  assign full     = (count_r == CNT_W'(MAX_ENTRIES));
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // append writes at the fill position
  assign wr_en   = accept && (in_cmd == CMD_APPEND) && !full;
  assign wr_data = {in_entry_id, in_size_m};

  // one block a cycle is read while unread blocks remain
  assign rd_en = (state_r == S_SCAN) && (rd_addr_r != count_r);

  assign rd_size = rd_data[SIZE_BITS-1:0];
  assign rd_id   = rd_data[DATA_W-1:SIZE_BITS];

  fbfs_mem #(
    .DEPTH  (MAX_ENTRIES),
    .IDX_W  (IDX_W),
    .DATA_W (DATA_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  fbfs_cmp #(
    .SIZE_BITS (SIZE_BITS)
  ) u_cmp (
    .blk_size  (rd_size),
    .req_size  (req_r),
    .best_left (best_r),
    .have      (have_r),
    .policy    (pol_r),
    .left      (left),
    .res       (cmp_res)
  );

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    rd_addr_nxt      = rd_addr_r;
    pend_nxt         = 1'b0;
    have_nxt         = have_r;
    best_nxt         = best_r;
    pick_nxt         = pick_r;
    req_nxt          = req_r;
    pol_nxt          = pol_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_status_nxt   = out_status_r;
    out_found_id_nxt = out_found_id_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_APPEND: begin
              out_valid_nxt    = 1'b1;
              out_found_id_nxt = '0;
              if (full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                out_status_nxt = STAT_DONE;
                count_nxt      = count_r + CNT_W'(1);
              end
            end
            CMD_CLEAR: begin
              out_valid_nxt    = 1'b1;
              out_status_nxt   = STAT_DONE;
              out_found_id_nxt = '0;
              count_nxt        = '0;
            end
            CMD_QUERY: begin
              req_nxt     = in_req_m;
              pol_nxt     = in_fit_policy;
              rd_addr_nxt = '0;
              have_nxt    = 1'b0;
              // empty table or unused policy: nothing to scan
              if ((count_r == '0) || !(in_fit_policy inside {POL_FIRST, POL_BEST, POL_WORST}))
              begin
                state_nxt = S_POST;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              // unused command answers done and leaves the table alone
              out_valid_nxt    = 1'b1;
              out_status_nxt   = STAT_DONE;
              out_found_id_nxt = '0;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rd_en) begin
          rd_addr_nxt = rd_addr_r + CNT_W'(1);
        end
        pend_nxt = rd_en;
        if (pend_r) begin
          if (cmp_res.take) begin
            have_nxt = 1'b1;
            best_nxt = left;
            pick_nxt = rd_id;
          end
          // stop at the first hit for first fit, else after the last block
          if ((cmp_res.take && (pol_r == POL_FIRST)) || (rd_addr_r == count_r)) begin
            state_nxt = S_POST;
            pend_nxt  = 1'b0;
          end
        end
      end

      S_POST: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = have_r ? STAT_FOUND : STAT_NOFIT;
          out_found_id_nxt = have_r ? pick_r : '0;
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_addr_r   <= '0;
      pend_r      <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_addr_r   <= rd_addr_nxt;
      pend_r      <= pend_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    best_r         <= best_nxt;
    pick_r         <= pick_nxt;
    req_r          <= req_nxt;
    pol_r          <= pol_nxt;
    out_status_r   <= out_status_nxt;
    out_found_id_r <= out_found_id_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_found_id = out_found_id_r;

endmodule

// ----- rtl/core/fbfs_checker.sv -----
// ----------------------------------------------------------------------------
// fbfs_checker
// port level checks of the free block fit search
// ----------------------------------------------------------------------------
module fbfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_cmd,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [15:0] out_found_id
);
  import fbfs_pkg::*;

  // a waiting word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_found_id))
    else $error("result word changed while stalled");

  // id only carried by a found word
  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_FOUND) |-> out_found_id == 16'd0)
    else $error("found id set on a word that is not found");

  // append answers at once with done or full
  a_append: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_APPEND)
      |=> out_valid && ((out_status == STAT_DONE) || (out_status == STAT_FULL)))
    else $error("append word missing or wrong status");

  // clear answers at once with done
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_CLEAR) |=> out_valid && (out_status == STAT_DONE))
    else $error("clear word missing or wrong status");

  // a query keeps the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_QUERY) |=> !in_ready)
    else $error("ready during query search");

endmodule

bind free_block_fit_search fbfs_checker u_fbfs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_cmd       (in_cmd),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_found_id (out_found_id)
);

// ----- bench/free_block_fit_search_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_block_fit_search_check
// watches both channels of the fit search, keeps its own copy of the free
// block table, predicts one result word per accepted input word and compares
// ----------------------------------------------------------------------------
module free_block_fit_search_check #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_entry_size,
  input  logic [15:0] in_entry_id,
  input  logic [31:0] in_request_size,
  input  logic [1:0]  in_fit_policy,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [15:0] out_found_id,
  output int          fail_count,
  output int          words_checked,
  output int          outcomes_waiting
);
  import fbfs_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] found_id;
  } fit_outcome_t;

  logic [31:0]  free_size [MAX_ENTRIES];
  logic [15:0]  free_id   [MAX_ENTRIES];
  int unsigned  free_count;
  fit_outcome_t awaited_outcomes[$];
  int           n_fail;
  int           n_checked;

  // applies one word to the table copy and returns the word it should give
  function automatic fit_outcome_t apply_word(input logic [1:0]  cmd,
                                              input logic [31:0] size,
                                              input logic [15:0] id,
                                              input logic [31:0] request,
                                              input logic [1:0]  policy);
    fit_outcome_t res;
    logic [31:0]  left;
    logic [31:0]  kept_left;
    logic         have;
    int unsigned  pick;
    int unsigned  i;
    res.status   = STAT_DONE;
    res.found_id = '0;
    have         = 1'b0;
    kept_left    = '0;
    pick         = 0;
    case (cmd)
      CMD_APPEND: begin
        if (free_count < MAX_ENTRIES) begin
          free_size[free_count] = size;
          free_id[free_count]   = id;
          free_count++;
        end else begin
          res.status = STAT_FULL;
        end
      end
      CMD_CLEAR: free_count = 0;
      CMD_QUERY: begin
        if (policy == POL_FIRST || policy == POL_BEST || policy == POL_WORST) begin
          for (i = 0; i < free_count; i++) begin
            if (free_size[i] >= request) begin
              left = free_size[i] - request;
              // strict compares keep the earlier entry on a tie
              if (!have || (policy == POL_BEST && left < kept_left) ||
                  (policy == POL_WORST && left > kept_left)) begin
                if (!(have && policy == POL_FIRST)) begin
                  have      = 1'b1;
                  kept_left = left;
                  pick      = i;
                end
              end
            end
          end
        end
        if (have) begin
          res.status   = STAT_FOUND;
          res.found_id = free_id[pick];
        end else begin
          res.status = STAT_NOFIT;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    fit_outcome_t want;
    if (!rst_n) begin
      free_count = 0;
      awaited_outcomes.delete();
      n_fail    = 0;
      n_checked = 0;
    end else begin
      if (in_valid && in_ready)
        awaited_outcomes.push_back(apply_word(in_cmd, in_entry_size, in_entry_id,
                                              in_request_size, in_fit_policy));
      if (out_valid && out_ready) begin
        n_checked++;
        if (awaited_outcomes.size() == 0) begin
          $error("result word with nothing awaited: status %0d, found_id %0h",
                 out_status, out_found_id);
          n_fail++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (out_status !== want.status) begin
            $error("out_status: expected %0d, got %0d", want.status, out_status);
            n_fail++;
          end
          if (out_found_id !== want.found_id) begin
            $error("out_found_id: expected %0h, got %0h", want.found_id, out_found_id);
            n_fail++;
          end
        end
      end
    end
    fail_count       <= n_fail;
    words_checked    <= n_checked;
    outcomes_waiting <= awaited_outcomes.size();
  end

endmodule

// ----- bench/free_block_fit_search_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_block_fit_search_test
// drives append, clear and query words into the fit search with random gaps
// on both sides, a long receiver hold-off and drains; the checker beside the
// block predicts and compares every result word
// ----------------------------------------------------------------------------
module free_block_fit_search_test;
  import fbfs_pkg::*;

  localparam int unsigned MAX_ENTRIES  = 16;
  localparam int          RANDOM_ITEMS = 800;
  localparam int          LONG_HOLD    = 80;
  // codes the block does not use
  localparam logic [1:0]  CMD_SPARE    = 2'd3;
  localparam logic [1:0]  POL_SPARE    = 2'd3;

  // how the sizes of one round are spread
  typedef enum int {MIX_TINY, MIX_WIDE, MIX_EDGES, MIX_MID} size_mix_t;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic [1:0]  in_cmd          = '0;
  logic [31:0] in_entry_size   = '0;
  logic [15:0] in_entry_id     = '0;
  logic [31:0] in_request_size = '0;
  logic [1:0]  in_fit_policy   = '0;
  logic        out_ready       = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_found_id;

  int fail_count;
  int words_checked;
  int outcomes_waiting;

  // sender and receiver pacing
  logic src_quiet   = 1'b0;
  logic sink_quiet  = 1'b0;
  int   hold_ticket = 0;

  // stimulus bookkeeping: sizes now in the table, to aim requests at them
  logic [31:0] held_sizes[$];
  int n_sent   = 0;
  int n_append = 0;
  int n_clear  = 0;
  int n_query  = 0;
  int n_spare  = 0;

  free_block_fit_search #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .SIZE_BITS  (32)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_entry_size  (in_entry_size),
    .in_entry_id    (in_entry_id),
    .in_request_size(in_request_size),
    .in_fit_policy  (in_fit_policy),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_found_id   (out_found_id)
  );

  free_block_fit_search_check #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_entry_size   (in_entry_size),
    .in_entry_id     (in_entry_id),
    .in_request_size (in_request_size),
    .in_fit_policy   (in_fit_policy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found_id    (out_found_id),
    .fail_count      (fail_count),
    .words_checked   (words_checked),
    .outcomes_waiting(outcomes_waiting)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // reset held low from the start, then released for the rest of the run
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // offers one word after a random gap and holds it until taken;
  // valid stays high across back-to-back words
  task automatic send_word(input logic [1:0]  cmd,
                           input logic [31:0] size,
                           input logic [15:0] id,
                           input logic [31:0] request,
                           input logic [1:0]  policy);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_entry_size   <= size;
    in_entry_id     <= id;
    in_request_size <= request;
    in_fit_policy   <= policy;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    case (cmd)
      CMD_APPEND: begin
        n_append++;
        if (held_sizes.size() < MAX_ENTRIES)
          held_sizes.push_back(size);
      end
      CMD_CLEAR: begin
        n_clear++;
        held_sizes.delete();
      end
      CMD_QUERY: n_query++;
      default:   n_spare++;
    endcase
  endtask

  // sender stops and waits for every awaited word to come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outcomes_waiting != 0);
  endtask

  function automatic logic [31:0] draw_size(input size_mix_t mix);
    case (mix)
      MIX_TINY:  return $urandom_range(0, 63);       // many ties
      MIX_WIDE:  return $urandom;
      // hugging both ends of the range
      MIX_EDGES: return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 7)
                                                     : $urandom_range(0, 7);
      default:   return $urandom_range(0, 4095);
    endcase
  endfunction

  // requests mostly land on, just above or just below a stored size
  function automatic logic [31:0] pick_request(input size_mix_t mix);
    logic [31:0] base;
    if (held_sizes.size() == 0 || $urandom_range(0, 2) == 0)
      return draw_size(mix);
    base = held_sizes[$urandom_range(0, held_sizes.size() - 1)];
    case ($urandom_range(0, 2))
      0:       return base;
      1:       return base + 32'd1;
      default: return base - 32'd1;
    endcase
  endfunction

  // one well-formed round: usually a clear, a run of appends, then queries,
  // with the odd random command or unused policy thrown in as noise
  task automatic random_round();
    size_mix_t mix;
    int        n_blocks;
    int        n_queries;
    logic [1:0] policy;
    mix = size_mix_t'($urandom_range(0, 3));
    // a quarter of rounds keep the old table, so it often overflows
    if ($urandom_range(0, 3) != 0)
      send_word(CMD_CLEAR, $urandom, 16'($urandom), $urandom, 2'($urandom_range(0, 3)));
    n_blocks = $urandom_range(0, 18);
    repeat (n_blocks)
      send_word(CMD_APPEND, draw_size(mix), 16'($urandom), $urandom,
                2'($urandom_range(0, 3)));
    n_queries = $urandom_range(1, 8);
    repeat (n_queries) begin
      policy = ($urandom_range(0, 15) == 0) ? POL_SPARE : 2'($urandom_range(0, 2));
      send_word(CMD_QUERY, $urandom, 16'($urandom), pick_request(mix), policy);
      if ($urandom_range(0, 11) == 0)
        send_word(2'($urandom_range(0, 3)), $urandom, 16'($urandom), $urandom,
                  2'($urandom_range(0, 3)));
    end
  endtask

  // receiver: random stall per word, quiet stretches, and a long hold-off
  // whenever the sender asks for one
  initial begin
    int stall;
    int seen_ticket;
    seen_ticket = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_ticket != seen_ticket) begin
        seen_ticket = hold_ticket;
        stall       = LONG_HOLD;
      end else if (sink_quiet) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 3);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int target;
    int round;
    do @(posedge clk); while (!rst_n);

    // unused command with every field busy
    send_word(CMD_SPARE, 32'hA5A5_5A5A, 16'h3C3C, 32'h0F0F_F0F0, POL_SPARE);
    // fill the table: extremes, a tie pair, then random small sizes
    send_word(CMD_APPEND, 32'd0,         16'h0000, 32'd0,         POL_FIRST);
    send_word(CMD_APPEND, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, POL_WORST);
    send_word(CMD_APPEND, 32'd100,       16'd1,    32'd0,         POL_BEST);
    send_word(CMD_APPEND, 32'd50,        16'd2,    32'd0,         POL_FIRST);
    send_word(CMD_APPEND, 32'd100,       16'd3,    32'd0,         POL_FIRST);
    repeat (11)
      send_word(CMD_APPEND, $urandom_range(0, 200), 16'($urandom), $urandom,
                2'($urandom_range(0, 3)));
    // table full, entry dropped
    send_word(CMD_APPEND, 32'd77, 16'hBEEF, 32'd0, POL_FIRST);
    // each policy on the same request, tie on best fit, then an unused policy and the largest request
    send_word(CMD_QUERY, 32'd0, 16'h0000, 32'd60,        POL_FIRST);
    send_word(CMD_QUERY, 32'd0, 16'h0000, 32'd60,        POL_BEST);
    send_word(CMD_QUERY, 32'd0, 16'h0000, 32'd60,        POL_WORST);
    send_word(CMD_QUERY, 32'd0, 16'h0000, 32'd0,         POL_SPARE);
    send_word(CMD_QUERY, 32'd0, 16'h0000, 32'hFFFF_FFFF, POL_BEST);
    // empty table, then a request above every block
    send_word(CMD_CLEAR, 32'd0, 16'h0000, 32'd0, POL_FIRST);
    send_word(CMD_QUERY, 32'd0, 16'h0000, 32'd1, POL_WORST);
    send_word(CMD_APPEND, 32'd7, 16'h1234, 32'd0, POL_FIRST);
    send_word(CMD_QUERY, 32'd0, 16'h0000, 32'd8, POL_BEST);
    drain();

    target = n_sent + RANDOM_ITEMS;
    round  = 0;
    while (n_sent < target) begin
      round++;
      src_quiet  = ($urandom_range(0, 4) == 0);
      sink_quiet <= ($urandom_range(0, 4) == 0);
      // receiver goes away for a while, sender keeps pushing
      if (round == 3 || round == 30)
        hold_ticket <= hold_ticket + 1;
      random_round();
      if (round % 20 == 0)
        drain();
    end

    drain();
    // let a late spurious word show up
    repeat (MAX_ENTRIES + 4) @(posedge clk);

    $display("sent %0d words: %0d appends, %0d clears, %0d queries, %0d unused commands",
             n_sent, n_append, n_clear, n_query, n_spare);
    $display("compared %0d result words across %0d rounds with hold-offs and drains",
             words_checked, round);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/fbfs_pkg.sv
rtl/core/fbfs_mem.sv
rtl/core/fbfs_cmp.sv
rtl/core/free_block_fit_search.sv
rtl/core/fbfs_checker.sv
bench/free_block_fit_search_check.sv
bench/free_block_fit_search_test.sv
